// File: rtl/i2a_pkg.sv
// Shared types, constants and helpers of the integer-to-ASCII formatter.
// No dependencies; rtl/integer_to_ascii_formatter.sv uses it.
package i2a_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

  // decimal digits of 2^VALUE_BITS - 1 (1233/4096 ~ log10(2)), hex digits
  localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DIG_W      = DEC_DIGITS * 4;
  localparam int HEX_W      = HEX_DIGITS * 4;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int LEFT_W     = $clog2(DEC_DIGITS + 1);

  typedef enum logic [1:0] {
    KIND_SDEC = 2'd0,
    KIND_UDEC = 2'd1,
    KIND_HEXL = 2'd2,
    KIND_HEXU = 2'd3
  } kind_e;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'

  // ASCII code of one digit: decimal digits and 0-9 of hex map to '0'..'9',
  // hex 10-15 map to a-f or A-F.
  function automatic logic [7:0] digit_char(input logic [3:0] dig, input kind_e kind);
    logic [7:0] base;
    begin
      base = (kind == KIND_HEXU) ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (dig < 4'd10) begin
        digit_char = CHAR_ZERO + {4'b0, dig};
      end else begin
        digit_char = base + {4'b0, dig - 4'd10};
      end
    end
  endfunction

endpackage

// File: rtl/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter top level: bit-serial binary-to-BCD converter,
// digit shift register and character output register. Uses i2a_pkg.
//
// A request carries a 32-bit value (tdata) and a kind (tuser: 0 signed decimal,
// 1 unsigned decimal, 2 lower-case hex, 3 upper-case hex). The block returns
// the ASCII characters of the number, most significant first, one per output
// transfer, with tlast on the final one; no leading zeros, zero gives "0" and
// a negative signed value gets a leading '-'. One request is in work at a
// time. A decimal request first runs the shift-and-add-3 conversion (one
// value bit per cycle), then emits the sign if any and walks the digit
// positions (10), where leading zeros are dropped without output. A hex
// request skips the conversion. Output back-pressure stalls the sign and
// digit output.
module integer_to_ascii_formatter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [i2a_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]                      s_axis_tuser_i,   // [1:0] kind
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,   // [7:0] character
  output logic                            m_axis_tlast_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e                           state_q, state_d;
  i2a_pkg::kind_e                   kind_q, kind_d;
  logic                             neg_q, neg_d;
  logic                             started_q, started_d;
  logic [i2a_pkg::VALUE_BITS-1:0]   bin_q, bin_d;
  logic [i2a_pkg::DIG_W-1:0]        dig_q, dig_d;
  logic [i2a_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [i2a_pkg::LEFT_W-1:0]       left_q, left_d;
  logic                             m_valid_q, m_valid_d;
  logic [7:0]                       m_data_q, m_data_d;
  logic                             m_last_q, m_last_d;

  logic                             s_accept;
  logic                             out_free;
  i2a_pkg::kind_e                   in_kind;
  logic [i2a_pkg::VALUE_BITS-1:0]   in_value;
  logic                             in_neg;
  logic [i2a_pkg::VALUE_BITS-1:0]   in_mag;
  logic [i2a_pkg::DIG_W-1:0]        dig_adj;
  logic [3:0]                       top_dig;
  logic                             skip_zero;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign in_kind  = i2a_pkg::kind_e'(s_axis_tuser_i);
  assign in_value = s_axis_tdata_i[i2a_pkg::VALUE_BITS-1:0];
  assign in_neg   = (in_kind == i2a_pkg::KIND_SDEC) && in_value[i2a_pkg::VALUE_BITS-1];
  // the most negative value negates onto itself, which is its magnitude unsigned
  assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
      dig_adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
                                                     : dig_q[4*i +: 4];
    end
  end

  assign top_dig   = dig_q[i2a_pkg::DIG_W-1 -: 4];
  assign skip_zero = !started_q && (top_dig == 4'd0) && (left_q != i2a_pkg::LEFT_W'(1));

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    neg_d     = neg_q;
    started_d = started_q;
    bin_d     = bin_q;
    dig_d     = dig_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          kind_d    = in_kind;
          neg_d     = in_neg;
          started_d = 1'b0;
          cnt_d     = '0;
          bin_d     = in_mag;
          if (in_kind == i2a_pkg::KIND_SDEC || in_kind == i2a_pkg::KIND_UDEC) begin
            dig_d   = '0;
            left_d  = i2a_pkg::LEFT_W'(i2a_pkg::DEC_DIGITS);
            state_d = ST_CONV;
          end else begin
            // hex digits left aligned in the digit register
            dig_d   = i2a_pkg::DIG_W'(in_value) << (i2a_pkg::DIG_W - i2a_pkg::HEX_W);
            left_d  = i2a_pkg::LEFT_W'(i2a_pkg::HEX_DIGITS);
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        dig_d = {dig_adj[i2a_pkg::DIG_W-2:0], bin_q[i2a_pkg::VALUE_BITS-1]};
        bin_d = bin_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == i2a_pkg::CNT_W'(i2a_pkg::VALUE_BITS - 1)) begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = i2a_pkg::CHAR_MINUS;
          m_last_d  = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip_zero) begin
          dig_d  = dig_q << 4;
          left_d = left_q - 1'b1;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = i2a_pkg::digit_char(top_dig, kind_q);
          m_last_d  = (left_q == i2a_pkg::LEFT_W'(1));
          started_d = 1'b1;
          dig_d     = dig_q << 4;
          left_d    = left_q - 1'b1;
          if (left_q == i2a_pkg::LEFT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= i2a_pkg::KIND_SDEC;
      neg_q     <= 1'b0;
      started_q <= 1'b0;
      bin_q     <= '0;
      dig_q     <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      neg_q     <= neg_d;
      started_q <= started_d;
      bin_q     <= bin_d;
      dig_q     <= dig_d;
      cnt_q     <= cnt_d;
      left_q    <= left_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_last_q  <= m_last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // a digit position always remains while emitting
  a_emit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> left_q != '0)
    else $error("emit state with no digits left");

  // an accepted request goes to conversion or straight to emission
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_CONV || state_q == ST_EMIT))
    else $error("accepted request did not start");

  // the sign character is never the final one
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o == i2a_pkg::CHAR_MINUS) |-> !m_axis_tlast_o)
    else $error("sign character marked last");

  // the sign goes out only for a negative signed request
  a_sign_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIGN |-> neg_q && kind_q == i2a_pkg::KIND_SDEC)
    else $error("sign state without negative signed value");

endmodule

// File: dv/i2a_checker.sv
// Checker for the integer-to-ASCII formatter: watches both stream channels,
// predicts the characters of each accepted request and compares them in order.
// Depends on i2a_pkg for the kind encoding and value width.
module i2a_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [i2a_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]                      s_axis_tuser_i,   // [1:0] kind
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [7:0]                      m_axis_tdata_i,   // [7:0] character
  input  logic                            m_axis_tlast_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_chars_o
);

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_DASH  = 8'h2D;
  localparam logic [7:0] ASCII_LOW_A = 8'h61;
  localparam logic [7:0] ASCII_UP_A  = 8'h41;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_t;

  char_t expected_chars[$];

  // Pushes the characters of one request, most significant first.
  function automatic void format_number(input i2a_pkg::kind_e kind,
                                        input logic [i2a_pkg::VALUE_BITS-1:0] value);
    logic [i2a_pkg::VALUE_BITS-1:0] mag;
    logic [7:0]                     digits[0:23];
    logic [3:0]                     nib;
    int                             count;
    char_t                          ch;
    begin
      mag   = value;
      count = 0;
      if (kind == i2a_pkg::KIND_SDEC && value[i2a_pkg::VALUE_BITS-1]) begin
        mag = -value;   // most negative value maps onto its own magnitude
        ch.character = ASCII_DASH;
        ch.last      = 1'b0;
        expected_chars.push_back(ch);
      end
      if (kind == i2a_pkg::KIND_SDEC || kind == i2a_pkg::KIND_UDEC) begin
        do begin
          digits[count] = ASCII_ZERO + 8'(mag % 10);
          mag = mag / 10;
          count++;
        end while (mag != 0);
      end else begin
        do begin
          nib = mag[3:0];
          if (nib < 4'd10) begin
            digits[count] = ASCII_ZERO + 8'(nib);
          end else begin
            digits[count] = ((kind == i2a_pkg::KIND_HEXU) ? ASCII_UP_A : ASCII_LOW_A)
                            + 8'(nib - 4'd10);
          end
          mag = mag >> 4;
          count++;
        end while (mag != 0);
      end
      for (int i = count - 1; i >= 0; i--) begin
        ch.character = digits[i];
        ch.last      = (i == 0);
        expected_chars.push_back(ch);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        format_number(i2a_pkg::kind_e'(s_axis_tuser_i),
                      s_axis_tdata_i[i2a_pkg::VALUE_BITS-1:0]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none actual %h last %b",
                   $time, m_axis_tdata_i, m_axis_tlast_i);
          fail_count_o++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata_i !== want.character) begin
            $display("%0t: character mismatch: expected %h actual %h",
                     $time, want.character, m_axis_tdata_i);
            fail_count_o++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $display("%0t: last mismatch: expected %b actual %b",
                     $time, want.last, m_axis_tlast_i);
            fail_count_o++;
          end
        end
      end
      pending_chars_o = expected_chars.size();
    end
  end

endmodule

// File: dv/tb_integer_to_ascii_formatter.sv
// Testbench top for the integer-to-ASCII formatter: clock, reset, request
// stimulus and output back-pressure; checking is done in dv/i2a_checker.sv.
// Depends on i2a_pkg and rtl/integer_to_ascii_formatter.sv.
module tb_integer_to_ascii_formatter;

  localparam int RANDOM_REQUESTS = 430;
  localparam int CYCLE_LIMIT     = 600000;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             s_axis_tvalid_i;
  logic                             s_axis_tready_o;
  logic [i2a_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i;
  logic [1:0]                       s_axis_tuser_i;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [7:0]                       m_axis_tdata_o;
  logic                             m_axis_tlast_o;

  int unsigned fail_count;
  int unsigned pending_chars;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned cycle_count = 0;

  integer_to_ascii_formatter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  i2a_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .pending_chars_o (pending_chars)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("integer_to_ascii_formatter test failed");
    $finish;
  end

  // Called right after a rising edge; returns at the edge that takes the request.
  task automatic send_request(input i2a_pkg::kind_e kind,
                              input logic [i2a_pkg::VALUE_BITS-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= i2a_pkg::IN_TDATA_W'($urandom());
      s_axis_tuser_i  <= 2'($urandom());
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= i2a_pkg::IN_TDATA_W'(value);
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Hold off new requests until every predicted character has come out.
  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_chars != 0);
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                              input int num);
    logic [i2a_pkg::VALUE_BITS-1:0] value;
    begin
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < num; i++) begin
        // mostly short numbers of random length, some full-width ones
        value = $urandom();
        if ($urandom_range(0, 3) != 0) begin
          value = value >> $urandom_range(0, i2a_pkg::VALUE_BITS - 1);
        end
        send_request(i2a_pkg::kind_e'($urandom_range(0, 3)), value);
        if (i == num / 2) begin
          drain();
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, sign handling, zero and all hex letters per kind
    send_request(i2a_pkg::KIND_SDEC, 32'h0000_0000);
    send_request(i2a_pkg::KIND_SDEC, 32'h0000_0001);
    send_request(i2a_pkg::KIND_SDEC, 32'hFFFF_FFFF);
    send_request(i2a_pkg::KIND_SDEC, 32'h8000_0000);
    send_request(i2a_pkg::KIND_SDEC, 32'h7FFF_FFFF);
    send_request(i2a_pkg::KIND_SDEC, 32'hFFFF_FFF6);
    send_request(i2a_pkg::KIND_SDEC, 32'h0000_000A);
    send_request(i2a_pkg::KIND_UDEC, 32'h0000_0000);
    send_request(i2a_pkg::KIND_UDEC, 32'h0000_0009);
    send_request(i2a_pkg::KIND_UDEC, 32'hFFFF_FFFF);
    send_request(i2a_pkg::KIND_UDEC, 32'h8000_0000);
    send_request(i2a_pkg::KIND_UDEC, 32'h3B9A_CA00);
    send_request(i2a_pkg::KIND_HEXL, 32'h0000_0000);
    send_request(i2a_pkg::KIND_HEXL, 32'hFFFF_FFFF);
    send_request(i2a_pkg::KIND_HEXL, 32'h89AB_CDEF);
    send_request(i2a_pkg::KIND_HEXL, 32'h0000_000F);
    send_request(i2a_pkg::KIND_HEXU, 32'h0000_0000);
    send_request(i2a_pkg::KIND_HEXU, 32'hFFFF_FFFF);
    send_request(i2a_pkg::KIND_HEXU, 32'h89AB_CDEF);
    send_request(i2a_pkg::KIND_HEXU, 32'h0000_0010);
    drain();

    random_phase(33, 49, RANDOM_REQUESTS / 3);
    random_phase(49, 33, RANDOM_REQUESTS / 3);
    random_phase(0, 0, RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3));

    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_chars != 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("integer_to_ascii_formatter test passed");
    end else begin
      $display("integer_to_ascii_formatter test failed");
    end
    $finish;
  end

endmodule
